// File: rtl/rtu_fgr_pkg.sv
// Shared types, codes and sizes for the RTU frame gap receiver.
package rtu_fgr_pkg;

    localparam int MAX_FRAME   = 256;
    localparam int FRAME_AW    = $clog2(MAX_FRAME);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_BYTE    = 3'd1;
    localparam logic [2:0] CMD_POLL    = 3'd2;
    localparam logic [2:0] CMD_TX_DONE = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_BYTE    = 3'd2;
    localparam logic [2:0] OP_POLL    = 3'd3;
    localparam logic [2:0] OP_TX_DONE = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    localparam logic [1:0] LINE_INITIAL   = 2'd0;
    localparam logic [1:0] LINE_IDLE      = 2'd1;
    localparam logic [1:0] LINE_RECEIVING = 2'd2;
    localparam logic [1:0] LINE_WAITING   = 2'd3;

    localparam logic [1:0] STAGE_START  = 2'd0;
    localparam logic [1:0] STAGE_ARMED  = 2'd1;
    localparam logic [1:0] STAGE_SHORT  = 2'd2;
    localparam logic [1:0] STAGE_FRAME  = 2'd3;

    localparam logic REG_SHORT_GAP = 1'b0;
    localparam logic REG_FRAME_GAP = 1'b1;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] rx_data;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [8:0] frame_length;
        logic [7:0] read_data;
        logic [1:0] line_state;
        logic [8:0] buffered_count;
    } t_out_item;

    typedef struct packed {
        logic [2:0]          op;
        logic [7:0]          rx_data;
        logic [FRAME_AW-1:0] read_addr;
        logic                read_ok;
    } t_op_item;

    typedef struct packed {
        logic [7:0] short_gap;
        logic [7:0] frame_gap;
    } t_gap_cfg;

endpackage

// File: rtl/rtu_frame_gap_receiver_unit.sv
// Top level of the RTU frame gap receiver: register port, front, queue and back.
//
// One request is accepted per clock cycle when the downstream side keeps up; each
// request gives exactly one result, via the queue and then the result register.
// The rate is set by the back end, which updates the silence timer, line state
// and poll stage once per cycle unless the output stalls, and uses the single-port
// frame buffer for at most one byte write or one read per request. The frame
// buffer holds no reset value: read only positions already written. The gap
// registers must be written only while no request is in flight.
module rtu_frame_gap_receiver_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  rtu_fgr_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output rtu_fgr_pkg::t_out_item o_out_item
);

    rtu_fgr_pkg::t_gap_cfg r_cfg;
    rtu_fgr_pkg::t_op_item front_op;
    rtu_fgr_pkg::t_op_item queue_op;
    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_valid;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_gap <= 8'd2;
            r_cfg.frame_gap <= 8'd4;
        end else if (cfg_write) begin
            if (paddr[2] == rtu_fgr_pkg::REG_SHORT_GAP) begin
                r_cfg.short_gap <= pwdata[7:0];
            end else begin
                r_cfg.frame_gap <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == rtu_fgr_pkg::REG_SHORT_GAP) ?
                    {24'd0, r_cfg.short_gap} : {24'd0, r_cfg.frame_gap};

    rtu_fgr_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_op         (front_op)
    );

    rtu_fgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_op    (queue_op)
    );

    rtu_fgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_op_valid  (queue_valid),
        .i_op        (queue_op),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: rtl/rtu_fgr_front.sv
// Front end: accepts requests and classifies them into operations for the queue.
module rtu_fgr_front (
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rtu_fgr_pkg::t_in_item i_in_item,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output rtu_fgr_pkg::t_op_item o_op
);

    always_comb begin
        o_op.rx_data   = i_in_item.rx_data;
        o_op.read_addr = i_in_item.read_index[rtu_fgr_pkg::FRAME_AW-1:0];
        o_op.read_ok   = ({1'b0, i_in_item.read_index} < 9'(rtu_fgr_pkg::MAX_FRAME));
        case (i_in_item.command)
            rtu_fgr_pkg::CMD_TICK:    o_op.op = rtu_fgr_pkg::OP_TICK;
            rtu_fgr_pkg::CMD_BYTE:    o_op.op = rtu_fgr_pkg::OP_BYTE;
            rtu_fgr_pkg::CMD_POLL:    o_op.op = rtu_fgr_pkg::OP_POLL;
            rtu_fgr_pkg::CMD_TX_DONE: o_op.op = rtu_fgr_pkg::OP_TX_DONE;
            rtu_fgr_pkg::CMD_READ:    o_op.op = rtu_fgr_pkg::OP_READ;
            default:                  o_op.op = rtu_fgr_pkg::OP_NOP;
        endcase
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid & ~i_queue_full;

endmodule

// File: rtl/rtu_fgr_queue.sv
// Short queue of classified operations between front and back.
module rtu_fgr_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rtu_fgr_pkg::t_op_item i_op,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output rtu_fgr_pkg::t_op_item o_op
);

    rtu_fgr_pkg::t_op_item r_slot [rtu_fgr_pkg::QUEUE_DEPTH];
    logic [rtu_fgr_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [rtu_fgr_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [rtu_fgr_pkg::QCNT_W-1:0] r_count, n_count;

    localparam logic [rtu_fgr_pkg::QPTR_W-1:0] LAST_SLOT =
        rtu_fgr_pkg::QPTR_W'(rtu_fgr_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    assign o_full  = (r_count == rtu_fgr_pkg::QCNT_W'(rtu_fgr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

endmodule

// File: rtl/rtu_fgr_back.sv
// Back end: line state, poll sequence, frame buffer and the result register.
module rtu_fgr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rtu_fgr_pkg::t_gap_cfg  i_cfg,
    input  logic                   i_op_valid,
    input  rtu_fgr_pkg::t_op_item  i_op,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output rtu_fgr_pkg::t_out_item o_out_item
);

    localparam logic [8:0] FRAME_FULL = 9'(rtu_fgr_pkg::MAX_FRAME);

    logic [7:0] r_frame_mem [rtu_fgr_pkg::MAX_FRAME];

    logic [7:0] r_timer, n_timer;
    logic [1:0] r_line, n_line;
    logic [1:0] r_stage, n_stage;
    logic [8:0] r_count, n_count;
    logic [8:0] n_length;
    logic       n_wr_en;

    logic       r_out_valid;
    logic [8:0] r_out_length;
    logic [1:0] r_out_line;
    logic [8:0] r_out_count;
    logic       r_out_rd_en;
    logic [7:0] r_out_rd_q;

    logic       over_short;
    logic       over_frame;
    logic [8:0] inc_count;

    assign over_short = (r_timer > i_cfg.short_gap);
    assign over_frame = (r_timer > i_cfg.frame_gap);
    assign inc_count  = r_count + 9'd1;

    always_comb begin
        n_timer  = r_timer;
        n_line   = r_line;
        n_stage  = r_stage;
        n_count  = r_count;
        n_length = '0;
        n_wr_en  = 1'b0;
        case (i_op.op)
            rtu_fgr_pkg::OP_TICK: begin
                if (r_timer != 8'hFF) begin
                    n_timer = r_timer + 8'd1;
                end
            end
            rtu_fgr_pkg::OP_BYTE: begin
                n_timer = '0;
                if (r_line == rtu_fgr_pkg::LINE_WAITING) begin
                    // discard the frame, drop the byte
                    n_count = '0;
                end else if (r_line != rtu_fgr_pkg::LINE_INITIAL) begin
                    if (r_count == '0) begin
                        n_line = rtu_fgr_pkg::LINE_RECEIVING;
                    end
                    if (r_count < FRAME_FULL) begin
                        n_wr_en = 1'b1;
                        n_count = inc_count;
                        if (inc_count >= FRAME_FULL) begin
                            n_line = rtu_fgr_pkg::LINE_WAITING;
                        end
                    end else begin
                        n_line = rtu_fgr_pkg::LINE_WAITING;
                    end
                end
            end
            rtu_fgr_pkg::OP_POLL: begin
                case (r_stage)
                    rtu_fgr_pkg::STAGE_START: begin
                        if (r_line != rtu_fgr_pkg::LINE_INITIAL || over_frame) begin
                            n_line  = rtu_fgr_pkg::LINE_IDLE;
                            n_count = '0;
                            n_stage = rtu_fgr_pkg::STAGE_ARMED;
                        end
                    end
                    rtu_fgr_pkg::STAGE_ARMED: begin
                        if (r_line == rtu_fgr_pkg::LINE_RECEIVING ||
                            r_line == rtu_fgr_pkg::LINE_WAITING) begin
                            n_stage = rtu_fgr_pkg::STAGE_SHORT;
                        end
                    end
                    default: begin
                        // short gap and frame gap stages share the end check
                        if (r_stage == rtu_fgr_pkg::STAGE_SHORT && over_short) begin
                            n_stage = rtu_fgr_pkg::STAGE_FRAME;
                            n_line  = rtu_fgr_pkg::LINE_WAITING;
                        end
                        if (over_frame) begin
                            n_stage  = rtu_fgr_pkg::STAGE_START;
                            n_length = r_count;
                        end
                    end
                endcase
            end
            rtu_fgr_pkg::OP_TX_DONE: begin
                n_line  = rtu_fgr_pkg::LINE_IDLE;
                n_timer = '0;
            end
            default: begin
            end
        endcase
    end

    // advance when the result register is free or being taken
    assign o_pop = i_op_valid & (~r_out_valid | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= '0;
            r_line      <= rtu_fgr_pkg::LINE_INITIAL;
            r_stage     <= rtu_fgr_pkg::STAGE_START;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_timer <= n_timer;
                r_line  <= n_line;
                r_stage <= n_stage;
                r_count <= n_count;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_length <= n_length;
            r_out_line   <= n_line;
            r_out_count  <= n_count;
            r_out_rd_en  <= (i_op.op == rtu_fgr_pkg::OP_READ) && i_op.read_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_wr_en) begin
            r_frame_mem[r_count[rtu_fgr_pkg::FRAME_AW-1:0]] <= i_op.rx_data;
        end
        if (o_pop && i_op.op == rtu_fgr_pkg::OP_READ) begin
            r_out_rd_q <= r_frame_mem[i_op.read_addr];
        end
    end

    assign o_out_valid               = r_out_valid;
    assign o_out_item.frame_length   = r_out_length;
    assign o_out_item.read_data      = r_out_rd_en ? r_out_rd_q : 8'd0;
    assign o_out_item.line_state     = r_out_line;
    assign o_out_item.buffered_count = r_out_count;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FRAME_FULL)
        else $error("byte count beyond frame size");

    a_write_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_wr_en) |-> (r_count < FRAME_FULL))
        else $error("buffer write at or beyond frame size");

    a_no_return_initial : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line != rtu_fgr_pkg::LINE_INITIAL) |=> (r_line != rtu_fgr_pkg::LINE_INITIAL))
        else $error("line returned to initial state");

    a_pop_loads_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("operation executed without a result");

endmodule

// File: tb/sv/rtu_frame_gap_checker.sv
// Checker for the RTU frame gap receiver: tracks the line, predicts and compares results.
`timescale 1ns / 100ps
module rtu_frame_gap_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  rtu_fgr_pkg::t_in_item  i_in_item,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  rtu_fgr_pkg::t_out_item i_out_item,
    output int                     o_mismatches,
    output int                     o_pending
);
    import rtu_fgr_pkg::*;

    localparam logic [7:0] SHORT_GAP_AT_RESET = 8'd2;
    localparam logic [7:0] FRAME_GAP_AT_RESET = 8'd4;

    logic [7:0] short_gap;
    logic [7:0] frame_gap;
    logic [7:0] silence;
    logic [1:0] line;
    logic [1:0] stage;
    logic [8:0] held_bytes;
    logic [7:0] frame_buf [MAX_FRAME];
    t_out_item  results_due [$];
    int         mismatch_count = 0;

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [8:0] advance_poll();
        logic [8:0] length;
        length = '0;
        case (stage)
            STAGE_START: begin
                if (line != LINE_INITIAL || silence > frame_gap) begin
                    line       = LINE_IDLE;
                    held_bytes = '0;
                    stage      = STAGE_ARMED;
                end
                return '0;
            end
            STAGE_ARMED: begin
                if (line == LINE_RECEIVING || line == LINE_WAITING)
                    stage = STAGE_SHORT;
                return '0;
            end
            STAGE_SHORT: begin
                if (silence > short_gap) begin
                    stage = STAGE_FRAME;
                    line  = LINE_WAITING;
                end
            end
            default: ;
        endcase
        // the frame check runs in the short-gap stage as well
        if (silence > frame_gap) begin
            stage  = STAGE_START;
            length = held_bytes;
        end
        return length;
    endfunction

    function automatic t_out_item predict_result(t_in_item req);
        t_out_item res;
        res = '0;
        case (req.command)
            CMD_TICK: begin
                if (silence != 8'hFF)
                    silence = silence + 8'd1;
            end
            CMD_BYTE: begin
                silence = '0;
                if (line == LINE_WAITING) begin
                    // a byte inside the gap drops the whole frame
                    held_bytes = '0;
                end else if (line != LINE_INITIAL) begin
                    if (held_bytes == 0)
                        line = LINE_RECEIVING;
                    if (held_bytes < MAX_FRAME) begin
                        frame_buf[held_bytes[FRAME_AW-1:0]] = req.rx_data;
                        held_bytes = held_bytes + 9'd1;
                    end
                    if (held_bytes >= MAX_FRAME)
                        line = LINE_WAITING;
                end
            end
            CMD_POLL: res.frame_length = advance_poll();
            CMD_TX_DONE: begin
                line    = LINE_IDLE;
                silence = '0;
            end
            CMD_READ: res.read_data = frame_buf[req.read_index];
            default: ;
        endcase
        res.line_state     = line;
        res.buffered_count = held_bytes;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item due;
        if (!i_rst_n) begin
            short_gap  = SHORT_GAP_AT_RESET;
            frame_gap  = FRAME_GAP_AT_RESET;
            silence    = '0;
            line       = LINE_INITIAL;
            stage      = STAGE_START;
            held_bytes = '0;
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SHORT_GAP)
                    short_gap = pwdata[7:0];
                else
                    frame_gap = pwdata[7:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result %h arrived with no request outstanding", i_out_item);
                    mismatch_count++;
                end else begin
                    due = results_due.pop_front();
                    check_field("frame_length", due.frame_length, i_out_item.frame_length);
                    check_field("read_data", due.read_data, i_out_item.read_data);
                    check_field("line_state", due.line_state, i_out_item.line_state);
                    check_field("buffered_count", due.buffered_count,
                                i_out_item.buffered_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(predict_result(i_in_item));
        end
        o_mismatches = mismatch_count;
        o_pending    = results_due.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the RTU frame gap receiver testbench: clock, reset, requests and verdict.
`timescale 1ns / 100ps
module testbench;
    import rtu_fgr_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_AFTER    = 700;
    localparam int HOLD_CYCLES   = 300;
    localparam int CALM_FROM     = 1000;
    localparam int CALM_TO       = 1300;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_item;
    int          mismatches;
    int          pending;

    int sent_count  = 0;
    int short_cfg   = 2;
    int frame_cfg   = 4;
    int quiet_count = 0;

    always #2 i_clk = ~i_clk;

    rtu_frame_gap_receiver_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    rtu_frame_gap_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic bit steady();
        return sent_count >= CALM_FROM && sent_count < CALM_TO;
    endfunction

    task automatic offer(input logic [2:0] cmd, input logic [7:0] data,
                         input logic [7:0] index);
        t_in_item req;
        req.command    = cmd;
        req.rx_data    = data;
        req.read_index = index;
        while (!steady() && $urandom_range(0, 99) < 19) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge i_clk); while (in_stall);
        sent_count++;
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        offer(cmd, 8'($urandom), 8'($urandom));
    endtask

    task automatic tick_run(input int count);
        repeat (count) send_cmd(CMD_TICK);
    endtask

    // wait until every request has its result, then realign to a rising edge
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one frame: arm the poll, bytes with short gaps, then walk the gap stages
    task automatic receive_round();
        int span;
        span = ($urandom_range(0, 39) == 0) ? $urandom_range(240, 260)
                                            : $urandom_range(1, 12);
        send_cmd(CMD_POLL);
        repeat (span) begin
            tick_run($urandom_range(0, short_cfg < 3 ? short_cfg : 3));
            case ($urandom_range(0, 29))
                0: begin
                    // open the short gap mid-frame and poll inside it
                    tick_run(short_cfg + 1);
                    send_cmd(CMD_POLL);
                end
                1, 2: offer(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
                3: send_cmd(CMD_READ);
                default: ;
            endcase
            send_cmd(CMD_BYTE);
        end
        send_cmd(CMD_POLL);
        tick_run(short_cfg + 1);
        send_cmd(CMD_POLL);
        tick_run((frame_cfg > short_cfg ? frame_cfg - short_cfg : 0) + $urandom_range(0, 2));
        send_cmd(CMD_POLL);
        if ($urandom_range(0, 7) == 0)
            send_cmd(CMD_TX_DONE);
        if ($urandom_range(0, 3) == 0)
            send_cmd(CMD_READ);
    endtask

    task automatic run_phase(input logic [7:0] short_gap, input logic [7:0] frame_gap,
                             input int budget);
        int first;
        drain();
        write_reg(REG_SHORT_GAP, short_gap);
        write_reg(REG_FRAME_GAP, frame_gap);
        short_cfg = short_gap;
        frame_cfg = frame_gap;
        first = sent_count;
        do receive_round(); while (sent_count - first < budget);
    endtask

    // result side: random stalls, one long hold-off counted here
    initial begin
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_count >= HOLD_AFTER) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= !steady() && $urandom_range(0, 99) < 19;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_count = 0;
        else
            quiet_count = quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("** rtu_frame_gap_receiver_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // initial line: byte dropped, poll held until the line has been silent
        offer(CMD_BYTE, 8'hFF, 8'h00);
        offer(CMD_POLL, 8'h00, 8'hFF);
        tick_run(5);
        offer(CMD_POLL, 8'hFF, 8'h00);
        offer(CMD_SPARE_A, 8'h00, 8'hFF);
        offer(CMD_SPARE_B, 8'hFF, 8'h00);
        offer(CMD_SPARE_C, 8'h55, 8'hAA);
        offer(CMD_TX_DONE, 8'h00, 8'h00);
        offer(CMD_BYTE, 8'h00, 8'hFF);
        offer(CMD_BYTE, 8'hFF, 8'h00);
        offer(CMD_READ, 8'hFF, 8'd0);
        offer(CMD_READ, 8'h00, 8'd1);
        offer(CMD_POLL, 8'h00, 8'h00);
        tick_run(3);
        offer(CMD_POLL, 8'h00, 8'h00);
        // byte between the short and the frame gap discards the frame
        offer(CMD_BYTE, 8'hA5, 8'h00);
        tick_run(5);
        offer(CMD_POLL, 8'h00, 8'h00);

        // fill the whole buffer: overflow forces waiting, every entry written
        offer(CMD_POLL, 8'h00, 8'h00);
        repeat (MAX_FRAME) send_cmd(CMD_BYTE);
        offer(CMD_READ, 8'h00, 8'hFF);
        offer(CMD_BYTE, 8'h3C, 8'h00);

        run_phase(8'd2, 8'd4, 200);
        run_phase(8'd0, 8'd0, 150);
        run_phase(8'd3, 8'd8, 250);
        run_phase(8'd255, 8'd255, 1);
        run_phase(8'd255, 8'd0, 1);
        run_phase(8'($urandom_range(1, 6)), 8'($urandom_range(7, 14)), 200);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("** rtu_frame_gap_receiver_unit: PASSED **");
        else
            $display("** rtu_frame_gap_receiver_unit: FAILED **");
        $finish;
    end

endmodule
